### hw/rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion shorthands for the checker modules.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define CHK_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define CHK_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

### hw/rtl/bmhq_pkg.sv
// bmhq_pkg: types, constants and compare helper for the binary max-heap queue.
// No dependencies; used by bmhq_core, binary_max_heap_queue, bmhq_checker and the testbench.
package bmhq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRIO_W   = 32;
	localparam int TAG_W    = 16;

	// stream layout
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_CNT_W  = 7;
	localparam int OUT_STS_W  = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic   op;
		entry_t entry;
	} cmd_t;

	typedef struct packed {
		entry_t           removed;
		entry_t           top;
		logic [CNT_W-1:0] count;
		status_t          status;
	} result_t;

	// signed priority compare, strict
	function automatic logic prio_gt(input logic [PRIO_W-1:0] a, input logic [PRIO_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

endpackage

### hw/rtl/binary_max_heap_queue.sv
// binary_max_heap_queue: stream-facing top of the 64-entry max-heap priority queue.
// Instantiates bmhq_core; uses bmhq_pkg.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+--------------------------------------------
// s_*     | in  | s_tvalid/s_tready  | tuser: op; tdata: priority_req, value_tag
// m_*     | out | m_tvalid/m_tready  | tdata: removed, top, entry_count, status
//
// Item steps: refused ops and a remove of the only entry go straight to the result; an
// insert climbs one level per read and compare / write-back pair, and a remove first
// reads the last entry, then sifts it down from the root the same way. Each sift level
// is a memory read step and a compare / write-back step through the shared comparator;
// that loop sets the rate.
// Reset clears the entry count and control; heap storage is not cleared.
// The finished item sits in the output register; s_tready returns as soon as the
// result moves there, so the next item is taken while it waits for m_tready.
module binary_max_heap_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bmhq_pkg::IN_DATA_W-1:0]      s_tdata,  // [31:0] priority_req, [47:32] value_tag
	input  logic [0:0]                          s_tuser,  // [0] op: 0 insert, 1 remove max
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bmhq_pkg::OUT_DATA_W-1:0]     m_tdata   // [31:0] removed_priority,
	                                                      // [47:32] removed_tag,
	                                                      // [79:48] top_priority,
	                                                      // [95:80] top_tag,
	                                                      // [102:96] entry_count,
	                                                      // [104:103] status, rest 0
);

	bmhq_pkg::cmd_t    cmd;
	bmhq_pkg::result_t res;
	logic              core_idle, res_valid, res_take;

	logic                                m_tvalid_q;
	logic [bmhq_pkg::OUT_DATA_W-1:0]     m_tdata_q;

	assign cmd.op         = s_tuser[0];
	assign cmd.entry.prio = s_tdata[31:0];
	assign cmd.entry.tag  = s_tdata[47:32];

	// core may hand over a result whenever the output register is free or draining
	assign res_take = !m_tvalid_q || m_tready;
	assign s_tready = core_idle;

	bmhq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid && core_idle),
		.cmd       (cmd),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= res_valid;
		end
	end

	// payload register, loaded when a result is handed over
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			m_tdata_q <= {7'b0,
			              bmhq_pkg::OUT_STS_W'(res.status),
			              bmhq_pkg::OUT_CNT_W'(res.count),
			              res.top.tag, res.top.prio,
			              res.removed.tag, res.removed.prio};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### hw/rtl/bmhq_core.sv
// bmhq_core: heap storage (64 x 48-bit array, 1 write / 2 registered reads)
// and the sift sequencer around one shared sift comparator plus a child-select compare. Uses bmhq_pkg.
module bmhq_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bmhq_pkg::cmd_t    cmd,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_take,
	output bmhq_pkg::result_t res
);

	localparam int AW = bmhq_pkg::IDX_W + 2;   // child index width, holds 2*pos+2

	bmhq_pkg::entry_t mem_q [bmhq_pkg::CAPACITY];
	bmhq_pkg::entry_t rd_a_q, rd_b_q;

	bmhq_pkg::state_t               state_q, state_d;
	logic [bmhq_pkg::CNT_W-1:0]     count_q, count_d;
	logic [bmhq_pkg::IDX_W-1:0]     pos_q, pos_d;
	bmhq_pkg::entry_t               cur_q, cur_d;
	bmhq_pkg::entry_t               root_q;
	bmhq_pkg::entry_t               rem_q, rem_d;
	bmhq_pkg::status_t              status_q, status_d;

	logic                           we;
	logic [bmhq_pkg::IDX_W-1:0]     waddr, raddr_a, raddr_b;
	bmhq_pkg::entry_t               wdata;

	logic [bmhq_pkg::IDX_W-1:0]     parent_idx, pick_idx;
	logic [AW-1:0]                  left_w, right_w, fill_w;
	logic                           left_ok, right_ok, pick_right;
	bmhq_pkg::entry_t               pick, cmp_other;
	logic                           cur_wins;
	logic                           is_full;

	assign parent_idx = (pos_q - 1'b1) >> 1;
	assign left_w     = {1'b0, pos_q, 1'b1};
	assign right_w    = left_w + 1'b1;
	assign fill_w     = AW'(count_q);
	assign left_ok    = left_w < fill_w;
	assign right_ok   = right_w < fill_w;
	// larger child; right wins ties
	assign pick_right = right_ok && !bmhq_pkg::prio_gt(rd_a_q.prio, rd_b_q.prio);
	assign pick       = pick_right ? rd_b_q : rd_a_q;
	assign pick_idx   = pick_right ? right_w[bmhq_pkg::IDX_W-1:0]
	                               : left_w[bmhq_pkg::IDX_W-1:0];

	// the shared comparator that decides every sift step
	assign cmp_other  = (state_q == bmhq_pkg::S_UP_CMP) ? rd_a_q : pick;
	assign cur_wins   = bmhq_pkg::prio_gt(cur_q.prio, cmp_other.prio);
	assign is_full    = count_q == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					if (cmd.op == bmhq_pkg::OP_INSERT) begin
						state_d = is_full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
					end else if (count_q <= bmhq_pkg::CNT_W'(1)) begin
						state_d = bmhq_pkg::S_DONE;
					end else begin
						state_d = bmhq_pkg::S_DN_LAST;
					end
				end
			end
			bmhq_pkg::S_UP_RD:   state_d = (pos_q == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
			bmhq_pkg::S_UP_CMP:  state_d = cur_wins ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DONE;
			bmhq_pkg::S_DN_LAST: state_d = bmhq_pkg::S_DN_RD;
			bmhq_pkg::S_DN_RD:   state_d = left_ok ? bmhq_pkg::S_DN_CMP : bmhq_pkg::S_DONE;
			bmhq_pkg::S_DN_CMP:  state_d = cur_wins ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_RD;
			bmhq_pkg::S_DONE:    if (res_take) state_d = bmhq_pkg::S_IDLE;
			default:             state_d = bmhq_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		count_d  = count_q;
		pos_d    = pos_q;
		cur_d    = cur_q;
		rem_d    = rem_q;
		status_d = status_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = cur_q;
		raddr_a  = '0;
		raddr_b  = '0;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					rem_d    = '0;
					status_d = bmhq_pkg::STS_OK;
					if (cmd.op == bmhq_pkg::OP_INSERT) begin
						if (is_full) begin
							status_d = bmhq_pkg::STS_FULL;
						end else begin
							pos_d   = count_q[bmhq_pkg::IDX_W-1:0];
							cur_d   = cmd.entry;
							count_d = count_q + 1'b1;
						end
					end else begin
						if (count_q == '0) begin
							status_d = bmhq_pkg::STS_EMPTY;
						end else begin
							rem_d   = root_q;
							count_d = count_q - 1'b1;
							raddr_a = bmhq_pkg::IDX_W'(count_q - 1'b1);
						end
					end
				end
			end
			bmhq_pkg::S_UP_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr_a = parent_idx;
				end
			end
			bmhq_pkg::S_UP_CMP: begin
				we = 1'b1;
				if (cur_wins) begin
					wdata = rd_a_q;   // parent moves down
					pos_d = parent_idx;
				end
			end
			bmhq_pkg::S_DN_LAST: begin
				cur_d = rd_a_q;       // last entry, headed for the root
				pos_d = '0;
			end
			bmhq_pkg::S_DN_RD: begin
				if (left_ok) begin
					raddr_a = left_w[bmhq_pkg::IDX_W-1:0];
					raddr_b = right_w[bmhq_pkg::IDX_W-1:0];
				end else begin
					we = 1'b1;
				end
			end
			bmhq_pkg::S_DN_CMP: begin
				we = 1'b1;
				if (!cur_wins) begin
					wdata = pick;     // child moves up
					pos_d = pick_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		rem_q    <= rem_d;
		status_q <= status_d;
		if (we && waddr == '0) root_q <= wdata;
	end

	assign idle           = state_q == bmhq_pkg::S_IDLE;
	assign res_valid      = state_q == bmhq_pkg::S_DONE;
	assign res.removed    = rem_q;
	assign res.top        = (count_q != '0) ? root_q : '0;
	assign res.count      = count_q;
	assign res.status     = status_q;

endmodule

### hw/rtl/bmhq_checker.sv
// bmhq_checker: port-level assertions for binary_max_heap_queue, bound to the top.
// Uses bmhq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmhq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [bmhq_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [0:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bmhq_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [6:0] cnt;
	logic [1:0] sts;
	logic       in_take;

	assign cnt     = m_tdata[102:96];
	assign sts     = m_tdata[104:103];
	assign in_take = s_tvalid && s_tready && (s_tuser[0] == s_tuser[0]) && (s_tdata == s_tdata);

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CHK_NOW(a_cnt_range, m_tvalid, cnt <= 7'(bmhq_pkg::CAPACITY))
	`CHK_NOW(a_full_cnt, m_tvalid && sts == bmhq_pkg::STS_FULL, cnt == 7'(bmhq_pkg::CAPACITY))
	`CHK_NOW(a_refused_zero, m_tvalid && sts != bmhq_pkg::STS_OK, m_tdata[47:0] == '0)
	`CHK_NEXT(a_busy_after_take, in_take, !s_tready)

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);

### test/tb_binary_max_heap_queue.sv
// tb_binary_max_heap_queue: self-checking stream testbench for the max-heap priority queue.
// Needs bmhq_pkg and binary_max_heap_queue; a local heap model predicts every result item.
module tb_binary_max_heap_queue;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        op;
		int          prio;
		logic [15:0] tag;
		bit          drain_first;  // hold this item back until every result is in
	} heap_cmd_t;

	typedef struct {
		logic [31:0]       rem_p;
		logic [15:0]       rem_t;
		logic [31:0]       top_p;
		logic [15:0]       top_t;
		logic [6:0]        count;
		bmhq_pkg::status_t status;
	} heap_result_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [bmhq_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // [31:0] priority_req, [47:32] value_tag
	logic [0:0]                      s_tuser  = '0;  // [0] op
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [bmhq_pkg::OUT_DATA_W-1:0] m_tdata;        // [31:0] removed_priority,
	                                                 // [47:32] removed_tag,
	                                                 // [79:48] top_priority, [95:80] top_tag,
	                                                 // [102:96] entry_count,
	                                                 // [104:103] status

	binary_max_heap_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// model heap: slots at or above fill_level are never read
	int           heap_prio [bmhq_pkg::CAPACITY];
	logic [15:0]  heap_tag  [bmhq_pkg::CAPACITY];
	int           fill_level = 0;

	heap_cmd_t    pending_cmds [$];
	heap_result_t expected_heap_results [$];
	heap_cmd_t    cur_cmd;
	heap_result_t want;
	int           n_sent = 0;   // items accepted, updated at the edge
	int           n_seen = 0;   // result items taken, updated at the edge
	int           errors = 0;
	logic         fire;

	function automatic void swap_slots(int a, int b);
		int          p;
		logic [15:0] t;
		p = heap_prio[a];
		t = heap_tag[a];
		heap_prio[a] = heap_prio[b];
		heap_tag[a]  = heap_tag[b];
		heap_prio[b] = p;
		heap_tag[b]  = t;
	endfunction

	// applies one item to the model heap and returns the result item it should produce
	function automatic heap_result_t predict_heap_step(heap_cmd_t c);
		heap_result_t r;
		int           pos;
		int           left;
		int           right;
		int           pick;
		bit           moving;
		r.rem_p  = '0;
		r.rem_t  = '0;
		r.status = bmhq_pkg::STS_OK;
		if (c.op == bmhq_pkg::OP_INSERT) begin
			if (fill_level >= bmhq_pkg::CAPACITY) begin
				r.status = bmhq_pkg::STS_FULL;
			end else begin
				heap_prio[fill_level] = c.prio;
				heap_tag[fill_level]  = c.tag;
				pos = fill_level;
				fill_level++;
				moving = 1'b1;
				// climb only while strictly above the parent
				while (moving && pos > 0) begin
					if (heap_prio[pos] > heap_prio[(pos - 1) / 2]) begin
						swap_slots(pos, (pos - 1) / 2);
						pos = (pos - 1) / 2;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else if (fill_level == 0) begin
			r.status = bmhq_pkg::STS_EMPTY;
		end else begin
			r.rem_p = heap_prio[0];
			r.rem_t = heap_tag[0];
			fill_level--;
			heap_prio[0] = heap_prio[fill_level];
			heap_tag[0]  = heap_tag[fill_level];
			pos = 0;
			moving = 1'b1;
			// larger child wins, right child on a tie; swap unless strictly greater
			while (moving) begin
				left  = 2 * pos + 1;
				right = left + 1;
				if (left >= fill_level) begin
					moving = 1'b0;
				end else begin
					pick = (right >= fill_level || heap_prio[left] > heap_prio[right]) ?
						left : right;
					if (heap_prio[pos] > heap_prio[pick]) begin
						moving = 1'b0;
					end else begin
						swap_slots(pos, pick);
						pos = pick;
					end
				end
			end
		end
		r.top_p = (fill_level > 0) ? heap_prio[0] : '0;
		r.top_t = (fill_level > 0) ? heap_tag[0] : '0;
		r.count = fill_level[6:0];
		return r;
	endfunction

	// random idling on both sides, switched off while items 400..599 go through
	function automatic bit take_break();
		return (n_sent < 400 || n_sent >= 600) && $urandom_range(0, 99) < 29;
	endfunction

	task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t ns: result %0d %s expected %0h actual %0h",
				$time, n_seen, name, exp_v, act_v);
		end
	endtask

	task automatic add_cmd(logic op, int prio, logic [15:0] tag, bit drain_first);
		heap_cmd_t c;
		c.op          = op;
		c.prio        = prio;
		c.tag         = tag;
		c.drain_first = drain_first;
		pending_cmds.push_back(c);
	endtask

	// driver: predicts at acceptance, then presents the next pending item or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				expected_heap_results.push_back(predict_heap_step(cur_cmd));
				n_sent <= n_sent + 1;
			end
			if (!s_tvalid || fire) begin
				if (pending_cmds.size() != 0 && !take_break() &&
				    (!pending_cmds[0].drain_first || (!fire && n_sent == n_seen))) begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_cmd.tag, cur_cmd.prio};
					s_tuser  <= cur_cmd.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: every result item against the oldest expectation, field by field
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_seen <= n_seen + 1;
				if (expected_heap_results.size() == 0) begin
					errors++;
					$display("%0t ns: result %0d expected none actual %0h",
						$time, n_seen, m_tdata);
				end else begin
					want = expected_heap_results.pop_front();
					field_check("removed_priority", want.rem_p, m_tdata[31:0]);
					field_check("removed_tag", 32'(want.rem_t), 32'(m_tdata[47:32]));
					field_check("top_priority", want.top_p, m_tdata[79:48]);
					field_check("top_tag", 32'(want.top_t), 32'(m_tdata[95:80]));
					field_check("entry_count", 32'(want.count), 32'(m_tdata[102:96]));
					field_check("status", 32'(want.status), 32'(m_tdata[104:103]));
					field_check("padding", '0,
						32'(m_tdata[bmhq_pkg::OUT_DATA_W-1:105]));
				end
			end
			m_tready <= !take_break();
		end
	end

	initial begin
		int gen;
		int phase;
		int phase_len;
		int ins_pct;
		int prio;
		logic op;

		// directed: remove on empty, extreme priorities and tags, ties, drain to empty
		add_cmd(bmhq_pkg::OP_REMOVE, 0, 16'h0000, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 0, 16'h0001, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, -1, 16'h0002, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 5, 16'h0010, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 5, 16'h0011, 1'b0);  // climbs past parent 0; the next 5 ties with it and stays below
		add_cmd(bmhq_pkg::OP_INSERT, 5, 16'h0012, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 3, 16'h0020, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 3, 16'h0021, 1'b0);
		for (int i = 0; i < 10; i++)
			add_cmd(bmhq_pkg::OP_REMOVE, 32'h5555_AAAA, 16'hA5A5, 1'b0);
		add_cmd(bmhq_pkg::OP_REMOVE, -1, 16'hFFFF, 1'b0);  // empty again
		add_cmd(bmhq_pkg::OP_INSERT, 7, 16'h0030, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 7, 16'h0031, 1'b0);
		add_cmd(bmhq_pkg::OP_INSERT, 7, 16'h0032, 1'b0);   // the remove below sifts down against one child of equal priority
		add_cmd(bmhq_pkg::OP_REMOVE, 0, 16'h0000, 1'b0);

		// random phases with varying insert mix; the first two fill past full,
		// then drain past empty
		gen = 0;
		phase = 0;
		while (gen < 950) begin
			case (phase)
				0: begin ins_pct = 100; phase_len = 72; end
				1: begin ins_pct = 0; phase_len = 70; end
				default: begin
					phase_len = $urandom_range(20, 120);
					case ($urandom_range(0, 4))
						0: ins_pct = 100;
						1: ins_pct = 0;
						2: ins_pct = 50;
						3: ins_pct = 75;
						default: ins_pct = 25;
					endcase
				end
			endcase
			for (int i = 0; i < phase_len && gen < 950; i++) begin
				op = ($urandom_range(0, 99) < ins_pct) ? bmhq_pkg::OP_INSERT
				                                       : bmhq_pkg::OP_REMOVE;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: prio = $urandom_range(0, 8) - 4;  // frequent ties
					4, 5, 6, 7: prio = $urandom;
					8: prio = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: prio = $urandom_range(0, 1) ? 0 : -1;
				endcase
				add_cmd(op, prio, 16'($urandom_range(0, 16'hFFFF)),
					i == 0 && (phase == 0 || $urandom_range(0, 2) == 0));
				gen++;
			end
			phase++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(posedge clk);
		while (n_sent != n_seen)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (errors == 0 && expected_heap_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
